/* hw/rtl/pt64_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_pkg
// Shared widths, small-prime table and mul-mod handshake type.
// ----------------------------------------------------------------------------
package pt64_pkg;

    localparam int CAND_W    = 64;
    localparam int PRIME_CNT = 12;
    localparam int PIDX_W    = 4;
    localparam int REM_W     = 6;
    localparam int BCNT_W    = 7;   // holds CAND_W itself

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    function automatic logic [REM_W-1:0] small_prime(input logic [PIDX_W-1:0] idx);
        logic [REM_W-1:0] p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd2;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/pt64_mulmod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_mulmod
// Bit-serial (x * y) mod n, multiplier MSB first, a double then a conditional add per bit.
// ----------------------------------------------------------------------------
module pt64_mulmod
    import pt64_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CAND_W-1:0] op_x,
    input  wire logic [CAND_W-1:0] op_y,
    input  wire logic [CAND_W-1:0] modulus,
    output mm_status_t             status,
    output logic      [CAND_W-1:0] product
);

    logic [CAND_W-1:0] acc_reg, acc_next;
    logic [CAND_W-1:0] x_reg, x_next;
    logic [CAND_W-1:0] y_reg, y_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CAND_W:0]   sum;

    always_comb begin
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        sum        = '0;
        if (start) begin
            acc_next   = '0;
            x_next     = op_x;
            y_next     = op_y;
            cnt_next   = BCNT_W'(CAND_W);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                // double
                sum        = {acc_reg, 1'b0};
                acc_next   = (sum >= {1'b0, modulus}) ? CAND_W'(sum - {1'b0, modulus})
                                                      : sum[CAND_W-1:0];
                phase_next = 1'b1;
            end else begin
                // conditional add of x
                sum = {1'b0, acc_reg} + {1'b0, x_reg};
                if (y_reg[CAND_W-1]) begin
                    acc_next = (sum >= {1'b0, modulus}) ? CAND_W'(sum - {1'b0, modulus})
                                                        : sum[CAND_W-1:0];
                end
                y_next     = {y_reg[CAND_W-2:0], 1'b0};
                cnt_next   = cnt_reg - BCNT_W'(1);
                phase_next = 1'b0;
                if (cnt_reg == BCNT_W'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule
`default_nettype wire

/* hw/rtl/primality_test_64bit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primality_test_64bit_top
// Deterministic 64-bit Miller-Rabin primality test, bases 2..37.
// ----------------------------------------------------------------------------
// One request carries a 64-bit candidate; one result carries prime_flag.
// The candidate is shifted in one bit per cycle while twelve small
// remainders mod 2..37 are updated in parallel; a hit settles the answer
// at once. Otherwise n-1 is split into d*2^s one bit per cycle and each of
// twelve bases runs square-and-multiply on a single shared bit-serial
// mod-multiplier that doubles and then conditionally adds for each
// multiplier bit. A full test of a prime needs up to about 127 products
// per base. One candidate is worked on at a time; the result sits in an
// output register, so a new request is taken while the old result waits.
// ----------------------------------------------------------------------------
module primality_test_64bit_top
    import pt64_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CAND_W-1:0] s_candidate,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_prime_flag
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DIVCHK, S_SHIFT, S_BASE, S_POW, S_WAIT_A, S_WAIT_B,
        S_CHECK, S_LOOP, S_LOOP_WAIT, S_NEXT, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CAND_W-1:0] n_reg, n_next;
    logic [CAND_W-1:0] nm1_reg, nm1_next;
    logic [CAND_W-1:0] sh_reg, sh_next;     // candidate shift line, then d
    logic [CAND_W-1:0] e_reg, e_next;
    logic [CAND_W-1:0] acc_reg, acc_next;
    logic [CAND_W-1:0] b_reg, b_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic [BCNT_W-1:0] s_reg, s_next;
    logic [BCNT_W-1:0] k_reg, k_next;
    logic [PIDX_W-1:0] base_reg, base_next;
    logic [REM_W-1:0]  rem_reg [PRIME_CNT];
    logic [REM_W-1:0]  rem_next [PRIME_CNT];
    logic              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_flag_reg, m_flag_next;

    logic              mm_start;
    logic [CAND_W-1:0] mm_x, mm_y, mm_prod;
    mm_status_t        mm_status;

    logic              hit;
    logic              hit_eq;
    logic [REM_W:0]    rem_tmp [PRIME_CNT];

    pt64_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_x    (mm_x),
        .op_y    (mm_y),
        .modulus (n_reg),
        .status  (mm_status),
        .product (mm_prod)
    );

    // Running remainders mod each small prime, one candidate bit per cycle.
    always_comb begin
        for (int i = 0; i < PRIME_CNT; i++) begin
            rem_tmp[i]  = {rem_reg[i], sh_reg[CAND_W-1]};
            rem_next[i] = (rem_tmp[i] >= {1'b0, small_prime(PIDX_W'(i))})
                        ? REM_W'(rem_tmp[i] - {1'b0, small_prime(PIDX_W'(i))})
                        : rem_tmp[i][REM_W-1:0];
        end
    end

    // First small prime that divides n, and whether n is that prime.
    always_comb begin
        hit    = 1'b0;
        hit_eq = 1'b0;
        for (int i = PRIME_CNT - 1; i >= 0; i--) begin
            if (rem_reg[i] == '0) begin
                hit    = 1'b1;
                hit_eq = (n_reg == {{(CAND_W-REM_W){1'b0}}, small_prime(PIDX_W'(i))});
            end
        end
    end

    // Multiplier operand select.
    always_comb begin
        mm_x = b_reg;
        mm_y = b_reg;
        if (state_reg == S_POW && e_reg[0]) begin
            mm_x = acc_reg;
        end else if (state_reg == S_LOOP) begin
            mm_x = acc_reg;
            mm_y = acc_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        nm1_next     = nm1_reg;
        sh_next      = sh_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        s_next       = s_reg;
        k_next       = k_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_flag_next  = m_flag_reg;
        mm_start     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    n_next     = s_candidate;
                    sh_next    = s_candidate;
                    cnt_next   = BCNT_W'(CAND_W);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                sh_next  = {sh_reg[CAND_W-2:0], 1'b0};
                cnt_next = cnt_reg - BCNT_W'(1);
                if (cnt_reg == BCNT_W'(1)) begin
                    state_next = S_DIVCHK;
                end
            end
            S_DIVCHK: begin
                nm1_next = n_reg - CAND_W'(1);
                sh_next  = n_reg - CAND_W'(1);
                s_next   = '0;
                if (n_reg < CAND_W'(2)) begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end else if (hit) begin
                    res_next   = hit_eq;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!sh_reg[0]) begin
                    sh_next = {1'b0, sh_reg[CAND_W-1:1]};
                    s_next  = s_reg + BCNT_W'(1);
                end else begin
                    base_next  = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                acc_next   = CAND_W'(1);
                b_next     = {{(CAND_W-REM_W){1'b0}}, small_prime(base_reg)};
                e_next     = sh_reg;
                state_next = S_POW;
            end
            S_POW: begin
                if (e_reg == '0) begin
                    state_next = S_CHECK;
                end else begin
                    mm_start   = 1'b1;
                    state_next = e_reg[0] ? S_WAIT_A : S_WAIT_B;
                end
            end
            S_WAIT_A: begin
                if (mm_status.done) begin
                    acc_next   = mm_prod;
                    mm_start   = 1'b1;          // b*b
                    state_next = S_WAIT_B;
                end
            end
            S_WAIT_B: begin
                if (mm_status.done) begin
                    b_next     = mm_prod;
                    e_next     = {1'b0, e_reg[CAND_W-1:1]};
                    state_next = S_POW;
                end
            end
            S_CHECK: begin
                if (acc_reg == CAND_W'(1) || acc_reg == nm1_reg) begin
                    state_next = S_NEXT;
                end else begin
                    k_next     = BCNT_W'(1);
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (k_reg >= s_reg) begin
                    res_next   = 1'b0;          // witness found
                    state_next = S_DONE;
                end else begin
                    mm_start   = 1'b1;
                    state_next = S_LOOP_WAIT;
                end
            end
            S_LOOP_WAIT: begin
                if (mm_status.done) begin
                    acc_next = mm_prod;
                    if (mm_prod == nm1_reg) begin
                        state_next = S_NEXT;
                    end else begin
                        k_next     = k_reg + BCNT_W'(1);
                        state_next = S_LOOP;
                    end
                end
            end
            S_NEXT: begin
                if (base_reg == PIDX_W'(PRIME_CNT - 1)) begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    base_next  = base_reg + PIDX_W'(1);
                    state_next = S_BASE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        nm1_reg    <= nm1_next;
        sh_reg     <= sh_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        base_reg   <= base_next;
        res_reg    <= res_next;
        m_flag_reg <= m_flag_next;
        for (int i = 0; i < PRIME_CNT; i++) begin
            if (state_reg == S_IDLE) begin
                rem_reg[i] <= '0;
            end else if (state_reg == S_DIV) begin
                rem_reg[i] <= rem_next[i];
            end
        end
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_prime_flag = m_flag_reg;

endmodule
`default_nettype wire

/* hw/rtl/pt64_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pt64_checker
// Port-level checks for the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
module pt64_checker
    import pt64_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [CAND_W-1:0] s_candidate,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_prime_flag
);

    // results never appear straight out of reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // one request in flight: no request taken in the cycle after one
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held after request taken");

    // a request taken while no result waits does not yield an instant result
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared without work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_prime_flag)))
        else $error("stalled result changed");

    // a waiting request keeps its candidate
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_candidate)))
        else $error("stalled request changed");

endmodule

bind primality_test_64bit_top pt64_checker u_pt64_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_candidate  (s_candidate),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_prime_flag (m_prime_flag)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-bit Miller-Rabin primality test.
// ----------------------------------------------------------------------------
// A queue of candidates feeds a clocked driver. Each accepted request gets its
// expected prime flag from a local predictor, which uses exact 128-bit products.
// A clocked monitor checks each result against the oldest expected flag.
// There are three idle phases: sender idle 27% with receiver idle 80%, then the
// reverse, then no idling. One long receiver hold-off lets the block back up.
// ----------------------------------------------------------------------------
module tb;
    import pt64_pkg::*;

    localparam int          N_RANDOM   = 130;
    localparam int          HOLD_LEN   = 3000;
    localparam int          DRAIN_CYC  = 400;
    localparam longint      CYCLE_MAX  = 20_000_000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CAND_W-1:0] s_candidate = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_prime_flag;

    logic [CAND_W-1:0] cand_q[$];      // candidates still to be sent
    bit                flag_q[$];      // expected prime flags, oldest first
    int                n_sent = 0;
    int                n_total = 0;
    int                n_mismatch = 0;
    int                snd_idle = 27;
    int                rcv_idle = 80;
    bit                go = 1'b0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    longint            cycles = 0;

    always #1 aclk = ~aclk;

    primality_test_64bit_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_candidate  (s_candidate),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_flag (m_prime_flag)
    );

    // ---- predictor --------------------------------------------------------
    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, n});
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] b;
        acc = 64'd1;
        b = a % n;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, b, n);
            b = mul_mod(b, b, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit prime_ref(logic [63:0] n);
        int unsigned bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        bit          pass;
        if (n < 64'd2) return 1'b0;
        foreach (bases[i])
            if (n % 64'(bases[i]) == 64'd0) return n == 64'(bases[i]);
        // odd, at least 41: split n-1 into d * 2^s
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (bases[i]) begin
            x = pow_mod(64'(bases[i]), d, n);
            if (x == 64'd1 || x == n - 64'd1) continue;
            pass = 1'b0;
            for (int k = 1; k < s; k++) begin
                x = mul_mod(x, x, n);
                if (x == n - 64'd1) begin
                    pass = 1'b1;
                    break;
                end
            end
            if (!pass) return 1'b0;
        end
        return 1'b1;
    endfunction

    // ---- driver: next request only once the current one is taken ----------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                flag_q = {flag_q, prime_ref(s_candidate)};
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (go && cand_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    s_valid     <= 1'b1;
                    s_candidate <= cand_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // idle rates follow progress through the request stream
    always @(posedge aclk) begin
        if (n_sent >= (2 * n_total) / 3) begin
            snd_idle <= 0;
            rcv_idle <= 0;
        end else if (n_sent >= n_total / 3) begin
            snd_idle <= 80;
            rcv_idle <= 27;
        end
    end

    // long receiver hold-off two requests into the no-idle phase; sender keeps going
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && n_total != 0 && n_sent == (2 * n_total) / 3 + 2) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle);
    end

    // ---- monitor ------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (flag_q.size() == 0) begin
                if (n_mismatch < 10)
                    $display("ERROR: unexpected result prime_flag=%0b", m_prime_flag);
                n_mismatch <= n_mismatch + 1;
            end else if (flag_q[0] !== m_prime_flag) begin
                if (n_mismatch < 10)
                    $display("ERROR: prime_flag exp=%0b got=%0b", flag_q[0], m_prime_flag);
                n_mismatch <= n_mismatch + 1;
                void'(flag_q.pop_front());
            end else begin
                void'(flag_q.pop_front());
            end
        end
    end

    // ---- watchdog -----------------------------------------------------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---- stimulus and end of run ----------------------------------------------
    initial begin
        logic [63:0] v;
        int          sel;
        int          n_big;
        logic [63:0] big_primes[4] = '{64'd18446744073709551557, 64'd2305843009213693951,
                                       64'd999999999989, 64'd2147483647};

        // directed: tiny values, small primes and their multiples, the full range,
        // large primes, and strong pseudoprimes to the first few bases
        cand_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd38, 64'd41, 64'd1369,
                   64'd1763, 64'd561, 64'd1000003, 64'd1373653, 64'd3215031751,
                   64'd4294967311, 64'd341550071728321, 64'd3825123056546413051,
                   64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'd18446744073709551557, 64'd2305843009213693951};

        // random: mostly cheap sizes, few large primes
        n_big = 0;
        repeat (N_RANDOM) begin
            sel = $urandom_range(9);
            case (sel)
                0, 1, 2, 3: v = 64'($urandom_range(65535));
                4, 5, 6:    v = {$urandom, $urandom};
                7:          v = {32'd0, $urandom | 32'd1};
                8:          v = 64'($urandom_range(65535) | 1) * 64'($urandom_range(65535) | 1);
                default: begin
                    if (n_big < 4) begin
                        v = big_primes[$urandom_range(3)];
                        n_big++;
                    end else begin
                        v = 64'($urandom_range(4095));
                    end
                end
            endcase
            cand_q = {cand_q, v};
        end
        n_total = cand_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        go <= 1'b1;

        while (cand_q.size() != 0 || s_valid) @(posedge aclk);
        while (flag_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pt64_pkg.sv
hw/rtl/pt64_mulmod.sv
hw/rtl/primality_test_64bit_top.sv
hw/rtl/pt64_checker.sv
tb/tb.sv
